@@ src/mqtt_inbound_frame_parser_core_defines.svh @@
// Assertion helpers shared by the parser modules.
// Both expect signals named clk and rst in the module that uses them.
`ifndef MQTT_INBOUND_FRAME_PARSER_CORE_DEFINES_SVH
`define MQTT_INBOUND_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define MQTTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MQTTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mqttp_pkg.sv @@
package mqttp_pkg;

  localparam int QueueDepth = 2;
  localparam int LenBytesMax = 4;
  localparam logic [3:0] PubTypeNibble = 4'h3;

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_ACK,
    PH_LEN,
    PH_TLEN_HI,
    PH_TLEN_LO,
    PH_TOPIC,
    PH_PAYLOAD,
    PH_DONE,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    CMD_CONNACK,
    CMD_SUBACK,
    CMD_UNSUBACK,
    CMD_PUBLISH
  } command_t;

  typedef enum logic [1:0] {
    BK_NONE,
    BK_TOPIC,
    BK_PAYLOAD
  } byte_kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TRUNC,
    ST_HEADER,
    ST_LENGTH,
    ST_QOS,
    ST_OVERLONG
  } status_t;

  // Which capture fields a result carries; the rest go out as zero.
  typedef enum logic [1:0] {
    FS_NONE,
    FS_ACK,
    FS_PUB
  } field_sel_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    byte_kind_t  byte_kind;
    logic        frame_end;
    status_t     status;
    field_sel_t  sel;
    logic [7:0]  return_code;
    logic [15:0] packet_id;
    logic [27:0] body_length;
    logic [15:0] topic_length;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] ack_header(command_t k);
    unique case (k)
      CMD_CONNACK:  return 8'h20;
      CMD_SUBACK:   return 8'h90;
      CMD_UNSUBACK: return 8'hB0;
      default:      return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ack_length(command_t k);
    unique case (k)
      CMD_CONNACK:  return 8'h02;
      CMD_SUBACK:   return 8'h03;
      CMD_UNSUBACK: return 8'h02;
      default:      return 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] ack_size(command_t k);
    unique case (k)
      CMD_CONNACK:  return 3'd4;
      CMD_SUBACK:   return 3'd5;
      CMD_UNSUBACK: return 3'd4;
      default:      return 3'd0;
    endcase
  endfunction

endpackage

@@ src/mqttp_ifs.sv @@
interface mqttp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [1:0] command;

  modport source (output valid, output data_byte, output last_byte, output command,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input command,
                output ready);
endinterface

interface mqttp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  byte_kind;
  logic        frame_end;
  logic [2:0]  status;
  logic [7:0]  return_code;
  logic [15:0] packet_id;
  logic [27:0] body_length;
  logic [15:0] topic_length;

  modport source (output valid, output out_byte, output byte_kind, output frame_end,
                  output status, output return_code, output packet_id,
                  output body_length, output topic_length, input ready);
  modport sink (input valid, input out_byte, input byte_kind, input frame_end,
                input status, input return_code, input packet_id,
                input body_length, input topic_length, output ready);
endinterface

@@ src/mqttp_front.sv @@
module mqttp_front (
  input  logic                 clk,
  input  logic                 rst,
  mqttp_in_if.sink             frame_bytes,
  input  mqttp_pkg::q_status_t q_stat,
  output logic                 push,
  output mqttp_pkg::entry_t    entry
);
  import mqttp_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  byte_pos, byte_pos_next;
  command_t    kind_held, kind_held_next;
  logic [27:0] len_acc, len_acc_next;
  logic [2:0]  len_cnt, len_cnt_next;
  logic [27:0] body_left, body_left_next;
  logic [15:0] topic_left, topic_left_next;
  logic [15:0] topic_len, topic_len_next;
  status_t     err, err_next;
  logic [7:0]  rc, rc_next;
  logic [15:0] pid, pid_next;

  logic        take;
  logic        last;
  logic        clear;
  logic [7:0]  b;
  command_t    cmd;
  logic [27:0] acc_sum;
  logic [27:0] body_dec;
  logic [15:0] tlen_full;
  logic        len_short;
  logic        topic_long;
  status_t     status;
  byte_kind_t  kind_out;

  function automatic status_t first_err(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  assign b     = frame_bytes.data_byte;
  assign last  = frame_bytes.last_byte;
  assign cmd   = command_t'(frame_bytes.command);
  assign frame_bytes.ready = !q_stat.full;
  assign take  = frame_bytes.valid && frame_bytes.ready;
  assign clear = rst || (take && last);

  // Length groups are disjoint, so the add is an OR at the group's place.
  always_comb begin
    unique case (len_cnt[1:0])
      2'd0:    acc_sum = len_acc | {21'd0, b[6:0]};
      2'd1:    acc_sum = len_acc | {14'd0, b[6:0], 7'd0};
      2'd2:    acc_sum = len_acc | {7'd0, b[6:0], 14'd0};
      default: acc_sum = len_acc | {b[6:0], 21'd0};
    endcase
  end

  assign body_dec   = body_left - 28'd1;
  assign tlen_full  = {topic_len[15:8], b};
  assign len_short  = acc_sum < 28'd2;
  assign topic_long = {12'd0, tlen_full} > body_dec;

  // Next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_FIRST: begin
        if (cmd == CMD_PUBLISH) begin
          if (b[7:4] != PubTypeNibble || b[2:1] != 2'b00) phase_next = PH_SKIP;
          else phase_next = PH_LEN;
        end else begin
          phase_next = PH_ACK;
        end
      end
      PH_LEN: begin
        if (b[7]) begin
          if (len_cnt == 3'(LenBytesMax - 1)) phase_next = PH_SKIP;
        end else if (len_short) begin
          phase_next = PH_SKIP;
        end else begin
          phase_next = PH_TLEN_HI;
        end
      end
      PH_TLEN_HI: phase_next = PH_TLEN_LO;
      PH_TLEN_LO: begin
        if (topic_long) phase_next = PH_SKIP;
        else if (tlen_full != 16'd0) phase_next = PH_TOPIC;
        else if (body_dec != 28'd0) phase_next = PH_PAYLOAD;
        else phase_next = PH_DONE;
      end
      PH_TOPIC: begin
        if (topic_left == 16'd1) phase_next = (body_dec != 28'd0) ? PH_PAYLOAD : PH_DONE;
      end
      PH_PAYLOAD: begin
        if (body_left == 28'd1) phase_next = PH_DONE;
      end
      default: phase_next = phase;
    endcase
  end

  // Datapath and result
  always_comb begin
    byte_pos_next   = byte_pos;
    kind_held_next  = kind_held;
    len_acc_next    = len_acc;
    len_cnt_next    = len_cnt;
    body_left_next  = body_left;
    topic_left_next = topic_left;
    topic_len_next  = topic_len;
    err_next        = err;
    rc_next         = rc;
    pid_next        = pid;
    kind_out        = BK_NONE;
    unique case (phase)
      PH_FIRST: begin
        kind_held_next = cmd;
        byte_pos_next  = 3'd1;
        if (cmd == CMD_PUBLISH) begin
          if (b[7:4] != PubTypeNibble) err_next = ST_HEADER;
          else if (b[2:1] != 2'b00) err_next = ST_QOS;
        end else if (b != ack_header(cmd)) begin
          err_next = ST_HEADER;
        end
      end
      PH_ACK: begin
        unique case (byte_pos)
          3'd1: if (b != ack_length(kind_held)) err_next = first_err(err, ST_LENGTH);
          3'd2: if (kind_held != CMD_CONNACK) pid_next = {b, 8'h00};
          3'd3: begin
            if (kind_held == CMD_CONNACK) rc_next = b;
            else pid_next = {pid[15:8], b};
          end
          3'd4: if (kind_held == CMD_SUBACK) rc_next = b;
          default: ;
        endcase
        if (byte_pos != 3'd7) byte_pos_next = byte_pos + 3'd1;
      end
      PH_LEN: begin
        len_acc_next = acc_sum;
        if (b[7]) begin
          len_cnt_next = len_cnt + 3'd1;
          if (len_cnt == 3'(LenBytesMax - 1)) err_next = first_err(err, ST_OVERLONG);
        end else begin
          body_left_next = acc_sum;
          if (len_short) err_next = first_err(err, ST_TRUNC);
        end
      end
      PH_TLEN_HI: begin
        topic_len_next = {b, 8'h00};
        body_left_next = body_dec;
      end
      PH_TLEN_LO: begin
        topic_len_next = tlen_full;
        body_left_next = body_dec;
        if (topic_long) err_next = first_err(err, ST_TRUNC);
        else topic_left_next = tlen_full;
      end
      PH_TOPIC: begin
        kind_out        = BK_TOPIC;
        topic_left_next = topic_left - 16'd1;
        body_left_next  = body_dec;
      end
      PH_PAYLOAD: begin
        kind_out       = BK_PAYLOAD;
        body_left_next = body_dec;
      end
      default: ;
    endcase
  end

  // Final status, from where the byte leaves the parse
  always_comb begin
    priority if (phase_next == PH_ACK) begin
      status = (byte_pos_next < ack_size(kind_held_next)) ? ST_TRUNC : err_next;
    end else if (phase_next == PH_SKIP) begin
      status = err_next;
    end else if (phase_next == PH_DONE) begin
      status = ST_OK;
    end else begin
      status = ST_TRUNC;
    end
  end

  always_comb begin
    entry.out_byte     = (kind_out != BK_NONE) ? b : 8'h00;
    entry.byte_kind    = kind_out;
    entry.frame_end    = last;
    entry.status       = last ? status : ST_OK;
    if (!last) entry.sel = FS_PUB;
    else if (status != ST_OK) entry.sel = FS_NONE;
    else if (phase_next == PH_ACK) entry.sel = FS_ACK;
    else entry.sel = FS_PUB;
    entry.return_code  = rc_next;
    entry.packet_id    = pid_next;
    entry.body_length  = len_acc_next;
    entry.topic_length = topic_len_next;
  end

  assign push = take && (last || kind_out != BK_NONE);

  always_ff @(posedge clk) begin
    if (clear) begin
      phase      <= PH_FIRST;
      byte_pos   <= 3'd0;
      kind_held  <= CMD_CONNACK;
      len_acc    <= 28'd0;
      len_cnt    <= 3'd0;
      body_left  <= 28'd0;
      topic_left <= 16'd0;
      topic_len  <= 16'd0;
      err        <= ST_OK;
      rc         <= 8'd0;
      pid        <= 16'd0;
    end else if (take) begin
      phase      <= phase_next;
      byte_pos   <= byte_pos_next;
      kind_held  <= kind_held_next;
      len_acc    <= len_acc_next;
      len_cnt    <= len_cnt_next;
      body_left  <= body_left_next;
      topic_left <= topic_left_next;
      topic_len  <= topic_len_next;
      err        <= err_next;
      rc         <= rc_next;
      pid        <= pid_next;
    end
  end

endmodule

@@ src/mqttp_fifo.sv @@
`include "mqtt_inbound_frame_parser_core_defines.svh"

module mqttp_fifo #(
  parameter int DEPTH = mqttp_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mqttp_pkg::entry_t     wr_entry,
  input  logic                  pop,
  output mqttp_pkg::entry_t     head,
  output mqttp_pkg::q_status_t  q_stat
);
  import mqttp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  `MQTTP_ASSERT_IMP(a_cnt_bound, 1'b1, count <= CNT_W'(DEPTH), "queue count past depth")
  `MQTTP_ASSERT_IMP(a_no_underrun, pop, !q_stat.empty, "pop from empty queue")
  `MQTTP_ASSERT_IMP(a_no_overrun, push && !pop, !q_stat.full, "push into full queue")

endmodule

@@ src/mqttp_back.sv @@
`include "mqtt_inbound_frame_parser_core_defines.svh"

module mqttp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  mqttp_pkg::q_status_t q_stat,
  input  mqttp_pkg::entry_t    head,
  output logic                 pop,
  mqttp_out_if.source          results
);
  import mqttp_pkg::*;

  logic   out_valid;
  entry_t out_reg;
  entry_t fmt;

  assign pop = !q_stat.empty && (!out_valid || results.ready);

  // Fields outside the result's class go out as zero.
  always_comb begin
    fmt = head;
    unique case (head.sel)
      FS_ACK: begin
        fmt.body_length  = 28'd0;
        fmt.topic_length = 16'd0;
      end
      FS_PUB: begin
        fmt.return_code = 8'd0;
        fmt.packet_id   = 16'd0;
      end
      default: begin
        fmt.return_code  = 8'd0;
        fmt.packet_id    = 16'd0;
        fmt.body_length  = 28'd0;
        fmt.topic_length = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_reg <= fmt;
  end

  assign results.valid        = out_valid;
  assign results.out_byte     = out_reg.out_byte;
  assign results.byte_kind    = out_reg.byte_kind;
  assign results.frame_end    = out_reg.frame_end;
  assign results.status       = out_reg.status;
  assign results.return_code  = out_reg.return_code;
  assign results.packet_id    = out_reg.packet_id;
  assign results.body_length  = out_reg.body_length;
  assign results.topic_length = out_reg.topic_length;

  `MQTTP_ASSERT_IMP(a_status_on_end, out_valid && !out_reg.frame_end, out_reg.status == ST_OK, "status on a mid-frame transfer")
  `MQTTP_ASSERT_IMP(a_err_fields_zero, out_valid && out_reg.status != ST_OK, out_reg.return_code == 8'd0 && out_reg.packet_id == 16'd0 && out_reg.body_length == 28'd0 && out_reg.topic_length == 16'd0, "capture fields on an error transfer")

endmodule

@@ src/mqtt_inbound_frame_parser_core.sv @@
// Channel      | Dir | Payload
// frame_bytes  | in  | data_byte, last_byte, command (read on first byte)
// results      | out | out_byte, byte_kind, frame_end, status, return_code,
//              |     | packet_id, body_length, topic_length
//
// One byte per cycle unless the queue is full; the front parser steps once per byte.
// A result is written to a queue slot at its byte's transfer and moves to the
// output register once it heads the queue and that register is empty or being taken.
// Reset clears the parse state, the queue pointers and the output valid.
// frame_bytes.ready falls while the queue is full, for every byte, including those
// that give no result; with results.ready held high the queue never fills.
module mqtt_inbound_frame_parser_core #(
  parameter int QUEUE_DEPTH = mqttp_pkg::QueueDepth
) (
  input logic         clk,
  input logic         rst,
  mqttp_in_if.sink    frame_bytes,
  mqttp_out_if.source results
);
  import mqttp_pkg::*;

  q_status_t q_stat;
  entry_t    wr_entry;
  entry_t    head;
  logic      push;
  logic      pop;

  mqttp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .q_stat      (q_stat),
    .push        (push),
    .entry       (wr_entry)
  );

  mqttp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  mqttp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

@@ tb/tb_mqtt_inbound_frame_parser_core.sv @@
module tb_mqtt_inbound_frame_parser_core;
  import mqttp_pkg::*;

  localparam int TOTAL_BYTES = 1750;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 50;

  // ack tables, indexed by command
  localparam logic [31:0] ACK_HDR = {8'h00, 8'hB0, 8'h90, 8'h20};
  localparam logic [31:0] ACK_LEN = {8'h00, 8'h02, 8'h03, 8'h02};
  localparam logic [11:0] ACK_SIZE = {3'd0, 3'd4, 3'd5, 3'd4};

  typedef struct packed {
    logic [7:0]  out_byte;
    byte_kind_t  byte_kind;
    logic        frame_end;
    status_t     status;
    logic [7:0]  return_code;
    logic [15:0] packet_id;
    logic [27:0] body_length;
    logic [15:0] topic_length;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    data;
    logic          lst;
    command_t      cmd;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  localparam frame_result_t NO_RESULT = '0;

  logic clk;
  logic rst;

  mqttp_in_if  frame_ch ();
  mqttp_out_if result_ch ();

  mqtt_inbound_frame_parser_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .frame_bytes(frame_ch),
    .results    (result_ch)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Directed frames: connack with command changing on later bytes, suback at the
  // extremes, unsuback cut short after bad header and length, publish with bad
  // type nibble, QoS 3, overlong length, zero length, a good frame with a byte
  // past the body, and a topic longer than the body.
  stim_row_t directed_rows [31] = '{
    '{8'h20, 1'b0, CMD_CONNACK,  1'b0, NO_RESULT},
    '{8'h02, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h00, 1'b0, CMD_SUBACK,   1'b0, NO_RESULT},
    '{8'hFF, 1'b1, CMD_UNSUBACK, 1'b1,
      '{8'h00, BK_NONE, 1'b1, ST_OK, 8'hFF, 16'h0000, 28'h0, 16'h0000}},
    '{8'h90, 1'b0, CMD_SUBACK,   1'b0, NO_RESULT},
    '{8'h03, 1'b0, CMD_SUBACK,   1'b0, NO_RESULT},
    '{8'hFF, 1'b0, CMD_SUBACK,   1'b0, NO_RESULT},
    '{8'hFF, 1'b0, CMD_SUBACK,   1'b0, NO_RESULT},
    '{8'h00, 1'b1, CMD_SUBACK,   1'b1,
      '{8'h00, BK_NONE, 1'b1, ST_OK, 8'h00, 16'hFFFF, 28'h0, 16'h0000}},
    '{8'hB1, 1'b0, CMD_UNSUBACK, 1'b0, NO_RESULT},
    '{8'h05, 1'b1, CMD_UNSUBACK, 1'b1,
      '{8'h00, BK_NONE, 1'b1, ST_TRUNC, 8'h00, 16'h0000, 28'h0, 16'h0000}},
    '{8'h00, 1'b1, CMD_PUBLISH,  1'b1,
      '{8'h00, BK_NONE, 1'b1, ST_HEADER, 8'h00, 16'h0000, 28'h0, 16'h0000}},
    '{8'h36, 1'b1, CMD_PUBLISH,  1'b1,
      '{8'h00, BK_NONE, 1'b1, ST_QOS, 8'h00, 16'h0000, 28'h0, 16'h0000}},
    '{8'h30, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h80, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h80, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h80, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h80, 1'b1, CMD_PUBLISH,  1'b1,
      '{8'h00, BK_NONE, 1'b1, ST_OVERLONG, 8'h00, 16'h0000, 28'h0, 16'h0000}},
    '{8'h30, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h00, 1'b1, CMD_PUBLISH,  1'b1,
      '{8'h00, BK_NONE, 1'b1, ST_TRUNC, 8'h00, 16'h0000, 28'h0, 16'h0000}},
    '{8'h31, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h04, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h00, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h01, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h41, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'hFF, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h99, 1'b1, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h30, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h03, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h00, 1'b0, CMD_PUBLISH,  1'b0, NO_RESULT},
    '{8'h02, 1'b1, CMD_PUBLISH,  1'b1,
      '{8'h00, BK_NONE, 1'b1, ST_TRUNC, 8'h00, 16'h0000, 28'h0, 16'h0000}}
  };

  // parser state as the predictor sees it
  phase_t      ph;
  logic [2:0]  pos;
  command_t    kind_held;
  logic [27:0] len_acc;
  logic [2:0]  len_cnt;
  logic [27:0] body_left;
  logic [15:0] topic_left;
  logic [15:0] topic_len;
  status_t     first_err;
  logic [7:0]  rc_held;
  logic [15:0] pid_held;

  frame_result_t pending_parse_results [$];
  logic [7:0]    frame_q [$];
  command_t      frame_cmd;
  int            bytes_sent;
  int            mismatch_count = 0;
  int            cycle_count;
  int            stall_left;
  int            stall_draw;
  bit            src_idle;
  logic          sink_idle;

  function automatic void add_frame_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic void queue_expected(input frame_result_t r);
    pending_parse_results.insert(pending_parse_results.size(), r);
  endfunction

  function automatic void clear_parse();
    ph = PH_FIRST;
    pos = '0;
    kind_held = CMD_CONNACK;
    len_acc = '0;
    len_cnt = '0;
    body_left = '0;
    topic_left = '0;
    topic_len = '0;
    first_err = ST_OK;
    rc_held = '0;
    pid_held = '0;
  endfunction

  function automatic void flag_error(status_t s);
    if (first_err == ST_OK) first_err = s;
  endfunction

  // Advances the parse by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_frame_byte(input logic [7:0] b, input logic lst,
                                          input command_t cmd, output frame_result_t r);
    byte_kind_t bk;
    logic [7:0] ob;
    status_t    st;
    bk = BK_NONE;
    ob = '0;
    r = '0;
    case (ph)
      PH_FIRST: begin
        clear_parse();
        kind_held = cmd;
        pos = 3'd1;
        if (cmd == CMD_PUBLISH) begin
          if (b[7:4] != PubTypeNibble) begin
            flag_error(ST_HEADER);
            ph = PH_SKIP;
          end else if (b[2:1] != 2'b00) begin
            flag_error(ST_QOS);
            ph = PH_SKIP;
          end else begin
            ph = PH_LEN;
          end
        end else begin
          ph = PH_ACK;
          if (b != ACK_HDR[8*cmd +: 8]) flag_error(ST_HEADER);
        end
      end
      PH_ACK: begin
        case (pos)
          3'd1: if (b != ACK_LEN[8*kind_held +: 8]) flag_error(ST_LENGTH);
          3'd2: if (kind_held != CMD_CONNACK) pid_held = {b, 8'h00};
          3'd3: begin
            if (kind_held == CMD_CONNACK) rc_held = b;
            else pid_held[7:0] = b;
          end
          3'd4: if (kind_held == CMD_SUBACK) rc_held = b;
          default: ;
        endcase
        if (pos < 3'd7) pos++;
      end
      PH_LEN: begin
        // 7-bit groups, least significant first, kept to 28 bits
        len_acc = len_acc + (28'(b[6:0]) << (7 * len_cnt[1:0]));
        if (b[7]) begin
          len_cnt++;
          if (len_cnt >= LenBytesMax) begin
            flag_error(ST_OVERLONG);
            ph = PH_SKIP;
          end
        end else begin
          body_left = len_acc;
          if (body_left < 2) begin
            flag_error(ST_TRUNC);
            ph = PH_SKIP;
          end else begin
            ph = PH_TLEN_HI;
          end
        end
      end
      PH_TLEN_HI: begin
        topic_len = {b, 8'h00};
        body_left--;
        ph = PH_TLEN_LO;
      end
      PH_TLEN_LO: begin
        topic_len[7:0] = b;
        body_left--;
        if (28'(topic_len) > body_left) begin
          flag_error(ST_TRUNC);
          ph = PH_SKIP;
        end else begin
          topic_left = topic_len;
          if (topic_left != 0) ph = PH_TOPIC;
          else ph = (body_left != 0) ? PH_PAYLOAD : PH_DONE;
        end
      end
      PH_TOPIC: begin
        bk = BK_TOPIC;
        ob = b;
        topic_left--;
        body_left--;
        if (topic_left == 0) ph = (body_left != 0) ? PH_PAYLOAD : PH_DONE;
      end
      PH_PAYLOAD: begin
        bk = BK_PAYLOAD;
        ob = b;
        body_left--;
        if (body_left == 0) ph = PH_DONE;
      end
      default: ;
    endcase

    if (!lst && bk == BK_NONE) return 1'b0;
    r.out_byte = ob;
    r.byte_kind = bk;
    r.frame_end = lst;
    if (!lst) begin
      r.body_length = len_acc;
      r.topic_length = topic_len;
      return 1'b1;
    end

    // short ack buffer outranks any recorded ack error
    if (ph == PH_ACK) st = (pos < ACK_SIZE[3*kind_held +: 3]) ? ST_TRUNC : first_err;
    else if (ph == PH_SKIP) st = first_err;
    else if (ph == PH_DONE) st = ST_OK;
    else st = ST_TRUNC;
    r.status = st;
    if (st == ST_OK) begin
      if (ph == PH_ACK) begin
        r.return_code = rc_held;
        r.packet_id = pid_held;
      end else begin
        r.body_length = len_acc;
        r.topic_length = topic_len;
      end
    end
    clear_parse();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result();
    frame_result_t want;
    if (pending_parse_results.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(result_ch.out_byte), '0);
      return;
    end
    want = pending_parse_results.pop_front();
    if (result_ch.out_byte !== want.out_byte)
      report_mismatch("out_byte", 32'(result_ch.out_byte), 32'(want.out_byte));
    if (result_ch.byte_kind !== want.byte_kind)
      report_mismatch("byte_kind", 32'(result_ch.byte_kind), 32'(want.byte_kind));
    if (result_ch.frame_end !== want.frame_end)
      report_mismatch("frame_end", 32'(result_ch.frame_end), 32'(want.frame_end));
    if (result_ch.status !== want.status)
      report_mismatch("status", 32'(result_ch.status), 32'(want.status));
    if (result_ch.return_code !== want.return_code)
      report_mismatch("return_code", 32'(result_ch.return_code), 32'(want.return_code));
    if (result_ch.packet_id !== want.packet_id)
      report_mismatch("packet_id", 32'(result_ch.packet_id), 32'(want.packet_id));
    if (result_ch.body_length !== want.body_length)
      report_mismatch("body_length", 32'(result_ch.body_length), 32'(want.body_length));
    if (result_ch.topic_length !== want.topic_length)
      report_mismatch("topic_length", 32'(result_ch.topic_length),
                      32'(want.topic_length));
  endtask

  // One byte transfer; a typed row supplies its own expectation.
  task automatic send_byte(input logic [7:0] b, input logic lst, input command_t cmd,
                           input logic typed, input frame_result_t want);
    int            gap;
    frame_result_t r;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.data_byte <= b;
    frame_ch.last_byte <= lst;
    frame_ch.command <= cmd;
    do @(posedge clk); while (!frame_ch.ready);
    if (parse_frame_byte(b, lst, cmd, r)) begin
      if (typed) queue_expected(want);
      else queue_expected(r);
    end else if (typed) begin
      queue_expected(want);
    end
    bytes_sent++;
  endtask

  task automatic build_frame();
    int         sel;
    int         body;
    int         tlen;
    int         cut;
    logic [7:0] hdr;
    frame_q.delete();
    sel = $urandom_range(0, 19);
    if (sel < 6) begin
      frame_cmd = command_t'($urandom_range(0, 2));
      add_frame_byte(ACK_HDR[8*frame_cmd +: 8]);
      add_frame_byte(ACK_LEN[8*frame_cmd +: 8]);
      repeat (int'(ACK_SIZE[3*frame_cmd +: 3]) - 2) add_frame_byte(8'($urandom));
      if ($urandom_range(0, 7) == 0) frame_q[0] = frame_q[0] ^ 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0) frame_q[1] = 8'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) add_frame_byte(8'($urandom));
      end else if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end else if (sel < 16) begin
      // mostly well-formed QoS 0 publish with random retain/dup bits and content
      frame_cmd = CMD_PUBLISH;
      hdr = {PubTypeNibble, 1'($urandom), 2'b00, 1'($urandom)};
      body = $urandom_range(2, 24);
      tlen = $urandom_range(0, body - 2);
      if ($urandom_range(0, 9) == 0) tlen = body - 2 + $urandom_range(1, 3);
      add_frame_byte(hdr);
      if ($urandom_range(0, 3) == 0) begin
        add_frame_byte(8'h80 | 8'(body));
        add_frame_byte(8'h00);
      end else begin
        add_frame_byte(8'(body));
      end
      add_frame_byte(8'(tlen >> 8));
      add_frame_byte(8'(tlen));
      repeat (body - 2) add_frame_byte(8'($urandom));
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_frame_byte(8'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end else if (sel < 17) begin
      // four-byte length, cut off long before the body ends
      frame_cmd = CMD_PUBLISH;
      add_frame_byte({PubTypeNibble, 3'b000, 1'($urandom)});
      repeat (3) add_frame_byte(8'($urandom) | 8'h80);
      add_frame_byte(8'($urandom) & 8'h7F);
      repeat (2) add_frame_byte(8'($urandom));
      repeat ($urandom_range(0, 10)) add_frame_byte(8'($urandom));
    end else if (sel < 18) begin
      frame_cmd = CMD_PUBLISH;
      add_frame_byte({PubTypeNibble, 4'b0000});
      if ($urandom_range(0, 1) == 0) add_frame_byte(8'($urandom_range(0, 1)));
      else repeat (4) add_frame_byte(8'($urandom) | 8'h80);
      repeat ($urandom_range(0, 3)) add_frame_byte(8'($urandom));
    end else if (sel < 19) begin
      frame_cmd = CMD_PUBLISH;
      if ($urandom_range(0, 1) == 0) add_frame_byte({PubTypeNibble, 4'($urandom)});
      else add_frame_byte(8'($urandom));
      repeat ($urandom_range(0, 6)) add_frame_byte(8'($urandom));
    end else begin
      frame_cmd = command_t'($urandom_range(0, 3));
      repeat ($urandom_range(1, 7)) add_frame_byte(8'($urandom));
    end
  endtask

  // result sink with a random stall drawn after each transfer while sink_idle
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (result_ch.ready) begin
      if (result_ch.valid) begin
        check_result();
        stall_draw = sink_idle ? $urandom_range(0, 6) : 0;
        if (stall_draw != 0) begin
          result_ch.ready <= 1'b0;
          stall_left <= stall_draw - 1;
        end
      end
    end else if (stall_left == 0) begin
      result_ch.ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mqtt_inbound_frame_parser_core regression: fail");
    $finish;
  end

  initial begin
    clear_parse();
    bytes_sent = 0;
    src_idle = 1'b1;
    rst <= 1'b1;
    sink_idle <= 1'b1;
    frame_ch.valid <= 1'b0;
    frame_ch.data_byte <= '0;
    frame_ch.last_byte <= 1'b0;
    frame_ch.command <= CMD_CONNACK;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(directed_rows); i++)
      send_byte(directed_rows[i].data, directed_rows[i].lst, directed_rows[i].cmd,
                directed_rows[i].typed, directed_rows[i].want);

    while (bytes_sent < TOTAL_BYTES) begin
      build_frame();
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle <= ($urandom_range(0, 3) != 0);
      // command is only read on the first byte; later ones carry noise
      for (int i = 0; i < frame_q.size(); i++)
        send_byte(frame_q[i], i == frame_q.size() - 1,
                  (i == 0) ? frame_cmd : command_t'($urandom_range(0, 3)), 1'b0, NO_RESULT);
    end
    frame_ch.valid <= 1'b0;

    while (pending_parse_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("mqtt_inbound_frame_parser_core regression: pass");
    else
      $display("mqtt_inbound_frame_parser_core regression: fail");
    $finish;
  end

endmodule
